[hw/rtl/time_window_rule_trigger_defines.svh]
// Assertion macros shared by the rule trigger RTL.
`ifndef TIME_WINDOW_RULE_TRIGGER_DEFINES_SVH
`define TIME_WINDOW_RULE_TRIGGER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define TWRT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define TWRT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/twrt_pkg.sv]
// Types and constants of the time-window rule trigger.
package twrt_pkg;

   // Field widths
   localparam int unsigned NOW_W   = 32;
   localparam int unsigned TOD_W   = 17;
   localparam int unsigned BITS_W  = 8;
   localparam int unsigned WIN_W   = 18;
   localparam int unsigned MINEV_W = 4;
   localparam int unsigned PER_W   = 24;
   localparam int unsigned CSR_W   = 24;
   localparam int unsigned IDX_W   = 3;
   localparam int unsigned CNT_W   = 4;

   // Conditions and events actually wired up
   localparam int unsigned MAX_CONDITIONS = 8;
   localparam int unsigned MAX_EVENTS     = 8;

   localparam logic [BITS_W-1:0] COND_USE_MASK = (MAX_CONDITIONS >= BITS_W) ?
      {BITS_W{1'b1}} : BITS_W'((64'd1 << MAX_CONDITIONS) - 64'd1);
   localparam logic [BITS_W-1:0] EVENT_USE_MASK = (MAX_EVENTS >= BITS_W) ?
      {BITS_W{1'b1}} : BITS_W'((64'd1 << MAX_EVENTS) - 64'd1);

   // Register indexes
   typedef enum logic [IDX_W-1:0] {
      CSR_RULE_MODE   = 3'd0,
      CSR_WINDOW_FROM = 3'd1,
      CSR_WINDOW_TO   = 3'd2,
      CSR_MIN_EVENTS  = 3'd3,
      CSR_PERIOD      = 3'd4,
      CSR_COND_MASK   = 3'd5,
      CSR_EVENT_MASK  = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_OFF        = 2'd0,
      MODE_MONOSTABLE = 2'd1,
      MODE_BISTABLE   = 2'd2
   } mode_type;

   typedef enum logic {
      OP_UPDATE = 1'b0,
      OP_TICK   = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_ON     = 2'd1,
      ACT_OFF    = 2'd2,
      ACT_REPEAT = 2'd3
   } action_type;

   // Configuration as seen by the engine
   typedef struct packed {
      logic [1:0]              rule_mode;
      logic signed [WIN_W-1:0] window_from;
      logic signed [WIN_W-1:0] window_to;
      logic [MINEV_W-1:0]      min_events;
      logic [PER_W-1:0]        period;
      logic [BITS_W-1:0]       cond_mask;
      logic [BITS_W-1:0]       event_mask;
   } cfg_type;

   // One registered input transaction
   typedef struct packed {
      logic              opcode;
      logic [NOW_W-1:0]  now;
      logic [TOD_W-1:0]  time_of_day;
      logic [BITS_W-1:0] cond_bits;
      logic [BITS_W-1:0] event_bits;
   } item_type;

   typedef struct packed {
      action_type action;
      logic       is_on;
   } result_type;

endpackage

[hw/rtl/twrt_if.sv]
// Request and response channel interfaces of the rule trigger.
interface twrt_req_if;
   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic [twrt_pkg::NOW_W-1:0]    now;
   logic [twrt_pkg::TOD_W-1:0]    time_of_day;
   logic [twrt_pkg::BITS_W-1:0]   cond_bits;
   logic [twrt_pkg::BITS_W-1:0]   event_bits;

   modport source (output valid, opcode, now, time_of_day, cond_bits, event_bits,
                   input ready);
   modport sink (input valid, opcode, now, time_of_day, cond_bits, event_bits,
                 output ready);
endinterface

interface twrt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic       is_on;

   modport source (output valid, action, is_on, input ready);
   modport sink (input valid, action, is_on, output ready);
endinterface

[hw/rtl/twrt_csr.sv]
// Configuration register file of the rule trigger.
module twrt_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [twrt_pkg::IDX_W-1:0]  csr_index,
   input  logic [twrt_pkg::CSR_W-1:0]  csr_wdata,
   output twrt_pkg::cfg_type           cfg
);

   twrt_pkg::cfg_type cfg_ff;
   twrt_pkg::cfg_type cfg_in;

   // Register decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            twrt_pkg::CSR_RULE_MODE:   cfg_in.rule_mode   = csr_wdata[1:0];
            twrt_pkg::CSR_WINDOW_FROM: cfg_in.window_from = csr_wdata[twrt_pkg::WIN_W-1:0];
            twrt_pkg::CSR_WINDOW_TO:   cfg_in.window_to   = csr_wdata[twrt_pkg::WIN_W-1:0];
            twrt_pkg::CSR_MIN_EVENTS:  cfg_in.min_events  = csr_wdata[twrt_pkg::MINEV_W-1:0];
            twrt_pkg::CSR_PERIOD:      cfg_in.period      = csr_wdata[twrt_pkg::PER_W-1:0];
            twrt_pkg::CSR_COND_MASK:   cfg_in.cond_mask   = csr_wdata[twrt_pkg::BITS_W-1:0];
            twrt_pkg::CSR_EVENT_MASK:  cfg_in.event_mask  = csr_wdata[twrt_pkg::BITS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rule_mode   <= twrt_pkg::MODE_OFF;
         cfg_ff.window_from <= '1;
         cfg_ff.window_to   <= '1;
         cfg_ff.min_events  <= '0;
         cfg_ff.period      <= '0;
         cfg_ff.cond_mask   <= '0;
         cfg_ff.event_mask  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hw/rtl/twrt_engine.sv]
// Rule state (active flag, deadline) and the per-transaction decision.
`include "time_window_rule_trigger_defines.svh"

module twrt_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  twrt_pkg::item_type    item,
   input  twrt_pkg::cfg_type     cfg,
   output twrt_pkg::result_type  result
);

   logic                            rule_on_ff;
   logic                            rule_on_in;
   logic [twrt_pkg::NOW_W-1:0]      deadline_ff;
   logic [twrt_pkg::NOW_W-1:0]      deadline_in;
   twrt_pkg::action_type            action;

   logic signed [twrt_pkg::WIN_W-1:0] tod_s;
   logic                              win_open;
   logic [twrt_pkg::BITS_W-1:0]       cm;
   logic [twrt_pkg::BITS_W-1:0]       em_bits;
   logic                              conds_ok;
   logic [twrt_pkg::CNT_W-1:0]        ev_count;
   logic                              enough_events;
   logic [twrt_pkg::NOW_W:0]          sum;
   logic [twrt_pkg::NOW_W-1:0]        new_deadline;
   logic                              bi_enable;

   // Enable window, wrapping past midnight when start is after end; open whenever either bound is negative
   assign tod_s = $signed({1'b0, item.time_of_day});
   assign win_open = cfg.window_from[twrt_pkg::WIN_W-1] || cfg.window_to[twrt_pkg::WIN_W-1]
      || ((cfg.window_from < cfg.window_to) && (cfg.window_from <= tod_s)
          && (tod_s <= cfg.window_to))
      || ((cfg.window_from > cfg.window_to) && ((cfg.window_from <= tod_s)
          || (tod_s <= cfg.window_to)));

   // Masked conditions and event count
   assign cm       = cfg.cond_mask & twrt_pkg::COND_USE_MASK;
   assign conds_ok = (item.cond_bits & cm) == cm;
   assign em_bits  = item.event_bits & cfg.event_mask & twrt_pkg::EVENT_USE_MASK;

   always_comb begin
      ev_count = '0;
      for (int i = 0; i < twrt_pkg::BITS_W; i++) begin
         ev_count = ev_count + twrt_pkg::CNT_W'(em_bits[i]);
      end
   end

   assign enough_events = ev_count >= cfg.min_events;
   assign bi_enable     = win_open && conds_ok;

   // now + period, saturating
   assign sum          = {1'b0, item.now} + (twrt_pkg::NOW_W + 1)'(cfg.period);
   assign new_deadline = sum[twrt_pkg::NOW_W] ? '1 : sum[twrt_pkg::NOW_W-1:0];

   // Next state and action
   always_comb begin
      rule_on_in  = rule_on_ff;
      deadline_in = deadline_ff;
      action      = twrt_pkg::ACT_NONE;
      case (cfg.rule_mode)
         twrt_pkg::MODE_MONOSTABLE: begin
            if (item.opcode == twrt_pkg::OP_UPDATE) begin
               if (!win_open || !conds_ok) begin
                  if (rule_on_ff) begin
                     rule_on_in = 1'b0;
                     action     = twrt_pkg::ACT_OFF;
                  end
               end else if (enough_events) begin
                  // retrigger pushes the deadline out
                  deadline_in = new_deadline;
                  if (!rule_on_ff) begin
                     rule_on_in = 1'b1;
                     action     = twrt_pkg::ACT_ON;
                  end
               end
            end else if (rule_on_ff && (item.now > deadline_ff)) begin
               rule_on_in = 1'b0;
               action     = twrt_pkg::ACT_OFF;
            end
         end
         twrt_pkg::MODE_BISTABLE: begin
            if (item.opcode == twrt_pkg::OP_UPDATE) begin
               if (bi_enable && !rule_on_ff) begin
                  rule_on_in = 1'b1;
                  action     = twrt_pkg::ACT_ON;
               end else if (rule_on_ff && !bi_enable) begin
                  rule_on_in = 1'b0;
                  action     = twrt_pkg::ACT_OFF;
               end
               if (rule_on_in && (cfg.period != '0)) begin
                  deadline_in = new_deadline;
               end
            end else if (rule_on_ff && (cfg.period != '0) && (item.now > deadline_ff)) begin
               action      = twrt_pkg::ACT_REPEAT;
               deadline_in = new_deadline;
            end
         end
         default: ;
      endcase
   end

   // State registers move only when a transaction is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         rule_on_ff  <= 1'b0;
         deadline_ff <= '0;
      end else if (fire) begin
         rule_on_ff  <= rule_on_in;
         deadline_ff <= deadline_in;
      end
   end

   assign result.action = action;
   assign result.is_on  = rule_on_in;

   `TWRT_ASSERT_NOW(a_on_sets_flag, fire && (result.action == twrt_pkg::ACT_ON), result.is_on, "turn-on reported with rule inactive")
   `TWRT_ASSERT_NOW(a_off_clears_flag, fire && (result.action == twrt_pkg::ACT_OFF), !result.is_on && rule_on_ff, "turn-off reported without a prior active rule")
   `TWRT_ASSERT_NOW(a_repeat_bistable, fire && (result.action == twrt_pkg::ACT_REPEAT), (cfg.rule_mode == twrt_pkg::MODE_BISTABLE) && rule_on_ff && (cfg.period != '0), "repeat outside an active bistable rule")
   `TWRT_ASSERT_NEXT(a_state_holds, !fire, $stable(rule_on_ff) && $stable(deadline_ff), "rule state changed with no transaction")

endmodule

[hw/rtl/time_window_rule_trigger.sv]
// Top level of the time-window rule trigger.
//
//   channel   direction  handshake             payload
//   req_chan  in         valid / ready         opcode, now, time_of_day, cond_bits, event_bits
//   rsp_chan  out        valid / ready         action, is_on
//   csr_*     in         csr_we (no back-pressure) csr_index, csr_wdata
//
// One transaction per cycle sustained while rsp_chan.ready holds; an accepted transaction
// passes the input register, the decision logic and the result register before rsp_chan.
// Reset is synchronous, active high: rule inactive, deadline zero, registers at defaults.
// A stalled result holds in its register while the input register takes one more
// transaction; with both full, req_chan.ready follows rsp_chan.ready.
module time_window_rule_trigger (
   input  logic                        clock,
   input  logic                        reset,
   twrt_req_if.sink                    req_chan,
   twrt_rsp_if.source                  rsp_chan,
   input  logic                        csr_we,
   input  logic [twrt_pkg::IDX_W-1:0]  csr_index,
   input  logic [twrt_pkg::CSR_W-1:0]  csr_wdata
);

   twrt_pkg::cfg_type    cfg;
   twrt_pkg::item_type   item_ff;
   twrt_pkg::result_type result;
   logic                 item_valid_ff;
   logic                 rsp_valid_ff;
   logic [1:0]           rsp_action_ff;
   logic                 rsp_is_on_ff;
   logic                 advance;
   logic                 req_fire;

   twrt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Handshakes
   assign advance        = item_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !item_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         item_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.opcode      <= req_chan.opcode;
         item_ff.now         <= req_chan.now;
         item_ff.time_of_day <= req_chan.time_of_day;
         item_ff.cond_bits   <= req_chan.cond_bits;
         item_ff.event_bits  <= req_chan.event_bits;
      end
   end

   twrt_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_action_ff <= result.action;
         rsp_is_on_ff  <= result.is_on;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.action = rsp_action_ff;
   assign rsp_chan.is_on  = rsp_is_on_ff;

endmodule
